### rtl/spectral_frame_moving_average_macros.svh
// Assertion macros for the spectral frame moving average RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef SPECTRAL_FRAME_MOVING_AVERAGE_MACROS_SVH
`define SPECTRAL_FRAME_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFMA_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfma same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SFMA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfma next-cycle check failed");

`endif

### rtl/sfma_pkg.sv
// Shared constants and types for the spectral frame moving average.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfma_pkg;

  localparam int BINS_DEF       = 1024;
  localparam int MAX_FRAMES_DEF = 8;

  localparam int MAG_W = 24;
  localparam int AVG_W = 4;
  localparam int SUM_W = 32;

  localparam int AVG_RESET = 4;

  // Quotient bits resolved per cycle by the divider.
  localparam int DIV_STEPS = 8;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_AVG_COUNT = 1'b0;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

`default_nettype wire

### rtl/spectral_frame_moving_average.sv
// Per-bin moving average over frames. One word is in flight at a time.
// Averaged path: sum and history read at accept, updated in ST_RD, divided in
// ST_DIV, output registered from ST_FIN; next word taken once back in ST_IDLE.
// Pass-through path (window of at most one frame): straight from ST_FIN.
// Synchronous active-high reset clears control state, sets avg_count to 4 and
// the bin counter to the first bin; history and sum memories are not cleared.
`default_nettype none

`include "spectral_frame_moving_average_macros.svh"

module spectral_frame_moving_average
  import sfma_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Input bins.
  input  wire logic              bin_valid,
  output logic                   bin_ready,
  input  wire logic [MAG_W-1:0]  magnitude,
  input  wire logic              frame_end,
  input  wire logic              seek_reset,
  // Averaged results.
  output logic                   avg_valid,
  input  wire logic              avg_ready,
  output logic      [MAG_W-1:0]  averaged,
  output logic                   last_bin,
  // Register port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int BIN_W  = $clog2(BINS);
  localparam int SLOT_W = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int OW     = CNT_W + 1;

  localparam logic [CNT_W-1:0] WIN_RESET =
    (AVG_RESET > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(AVG_RESET);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;

  // Configuration and frame bookkeeping.
  logic [AVG_W-1:0]  avg_count;
  logic [CNT_W-1:0]  frame_window;
  logic [CNT_W-1:0]  frames_held;
  logic [SLOT_W-1:0] write_slot;
  logic [BIN_W-1:0]  bin_index;

  // Word in flight.
  logic [MAG_W-1:0]  mag_r;
  logic [BIN_W-1:0]  bin_r;
  logic [SLOT_W-1:0] wslot_r;
  logic [CNT_W-1:0]  count_r;
  logic              full_r;
  logic              held_nz_r;
  logic              last_r;
  logic [MAG_W-1:0]  quot_r;

  // ---------------------------------------------------------------------------
  // Register port. Only the window length register exists; it is to be written while
  // the block is idle, which the block does not enforce; it takes effect at the next frame.
  // ---------------------------------------------------------------------------
  logic              cfg_wr;
  logic [ADDR_W-3:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[ADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (cfg_index == REG_AVG_COUNT) ? DATA_W'(avg_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= AVG_W'(AVG_RESET);
    end else if (cfg_wr && cfg_index == REG_AVG_COUNT) begin
      avg_count <= pwdata[AVG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-word decisions taken when a word is accepted. A seek on the first bin
  // of a frame empties the history before this word is counted; the window is
  // latched on the first bin and clamped to the ring depth.
  // ---------------------------------------------------------------------------
  logic              bin_accept;
  logic              at_first;
  logic              seek_now;
  logic [CNT_W-1:0]  win_reg;
  logic [CNT_W-1:0]  win_eff;
  logic [CNT_W-1:0]  fh_eff;
  logic [SLOT_W-1:0] ws_eff;
  logic [CNT_W-1:0]  fh_mod;
  logic [OW-1:0]     oldest_sum;
  logic [SLOT_W-1:0] oldest;
  logic              pass;
  logic              full;
  logic              last;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] ws_inc;

  assign bin_ready  = (state == ST_IDLE);
  assign bin_accept = bin_valid && bin_ready;

  assign at_first = (bin_index == '0);
  assign seek_now = at_first && seek_reset;
  assign win_reg  = (32'(avg_count) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(avg_count);
  assign win_eff  = at_first ? win_reg : frame_window;
  assign fh_eff   = seek_now ? '0 : frames_held;
  assign ws_eff   = seek_now ? '0 : write_slot;
  assign pass     = (win_eff <= CNT_W'(1));
  assign full     = (fh_eff >= win_eff);
  assign count    = full ? fh_eff : fh_eff + 1'b1;
  assign last     = frame_end || (bin_index == BIN_W'(BINS - 1));

  // The oldest frame in the window sits frames_held slots behind the write slot.
  assign fh_mod     = (fh_eff == CNT_W'(MAX_FRAMES)) ? '0 : fh_eff;
  assign oldest_sum = OW'(ws_eff) + OW'(MAX_FRAMES) - OW'(fh_mod);
  assign oldest     = (oldest_sum >= OW'(MAX_FRAMES)) ?
                      SLOT_W'(oldest_sum - OW'(MAX_FRAMES)) : SLOT_W'(oldest_sum);

  assign ws_inc = (ws_eff == SLOT_W'(MAX_FRAMES - 1)) ? '0 : ws_eff + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_window <= WIN_RESET;
      frames_held  <= '0;
      write_slot   <= '0;
      bin_index    <= '0;
    end else if (bin_accept) begin
      frame_window <= win_eff;
      bin_index    <= last ? '0 : bin_index + 1'b1;
      // Bookkeeping moves on at the end of each averaged frame; a pass-through
      // frame leaves the history exactly as it was, apart from a seek.
      if (last && !pass) begin
        frames_held <= full ? fh_eff : fh_eff + 1'b1;
        write_slot  <= ws_inc;
      end else begin
        frames_held <= fh_eff;
        write_slot  <= ws_eff;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memories. The sum and the leaving history value are read at accept time,
  // modified in ST_RD and written back in the same cycle. Only one word is in
  // flight, so a read never overlaps a pending write to the same bin.
  // ---------------------------------------------------------------------------
  mem_ctl_t          mem_ctl;
  logic [SUM_W-1:0]  sum_q;
  logic [MAG_W-1:0]  hist_q;
  logic [SUM_W-1:0]  sum_new;

  assign mem_ctl.rd = bin_accept && !pass;
  assign mem_ctl.wr = (state == ST_RD);

  // Sums wrap modulo 2^SUM_W, as the running total is defined.
  assign sum_new = (held_nz_r ? sum_q : '0) - (full_r ? SUM_W'(hist_q) : '0)
                 + SUM_W'(mag_r);

  sfma_mem #(
    .BINS       (BINS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_bin  (bin_index),
    .rd_slot (oldest),
    .sum_q   (sum_q),
    .hist_q  (hist_q),
    .wr_bin  (bin_r),
    .wr_slot (wslot_r),
    .wr_sum  (sum_new),
    .wr_mag  (mag_r)
  );

  // ---------------------------------------------------------------------------
  // Divider: the updated sum over the frame count, truncated.
  // ---------------------------------------------------------------------------
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  sfma_div #(
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mem_ctl.wr),
    .dividend (sum_new),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Word capture and sequencing.
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free = !avg_valid || avg_ready;

  always_ff @(posedge clk) begin
    if (bin_accept) begin
      mag_r     <= magnitude;
      bin_r     <= bin_index;
      wslot_r   <= ws_eff;
      count_r   <= count;
      full_r    <= full;
      held_nz_r <= (fh_eff != '0);
      last_r    <= last;
      // In pass-through the input goes straight to the result.
      if (pass) begin
        quot_r <= magnitude;
      end
    end else if (state == ST_DIV && div_done) begin
      quot_r <= div_quo[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (bin_accept) begin
            state <= pass ? ST_FIN : ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a finished word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      avg_valid <= 1'b1;
    end else if (avg_ready) begin
      avg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      averaged <= quot_r;
      last_bin <= last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `SFMA_IMPLIES(a_wr_only_in_rd, mem_ctl.wr, state == ST_RD)
  `SFMA_IMPLIES(a_done_only_in_div, div_done, state == ST_DIV)
  `SFMA_NEXT(a_one_word_in_flight, bin_accept, !bin_ready)
  `SFMA_NEXT(a_seek_empties, bin_accept && seek_now, frames_held <= CNT_W'(1))

endmodule

`default_nettype wire

### rtl/sfma_mem.sv
// Frame history ring and per-bin running sums, both memories with registered reads.
// Depends on sfma_pkg.
`default_nettype none

module sfma_mem
  import sfma_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic                          clk,
  input  wire mem_ctl_t                      ctl,
  input  wire logic [$clog2(BINS)-1:0]       rd_bin,
  input  wire logic [$clog2(MAX_FRAMES)-1:0] rd_slot,
  output logic      [SUM_W-1:0]              sum_q,
  output logic      [MAG_W-1:0]              hist_q,
  input  wire logic [$clog2(BINS)-1:0]       wr_bin,
  input  wire logic [$clog2(MAX_FRAMES)-1:0] wr_slot,
  input  wire logic [SUM_W-1:0]              wr_sum,
  input  wire logic [MAG_W-1:0]              wr_mag
);

  localparam int HIST_DEPTH = MAX_FRAMES * BINS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  logic [SUM_W-1:0] sums [BINS];
  logic [MAG_W-1:0] hist [HIST_DEPTH];

  logic [HIST_AW-1:0] hist_rd_addr;
  logic [HIST_AW-1:0] hist_wr_addr;

  // The ring is laid out slot-major: one row of BINS entries per stored frame.
  assign hist_rd_addr = HIST_AW'(rd_slot) * HIST_AW'(BINS) + HIST_AW'(rd_bin);
  assign hist_wr_addr = HIST_AW'(wr_slot) * HIST_AW'(BINS) + HIST_AW'(wr_bin);

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      sum_q  <= sums[rd_bin];
      hist_q <= hist[hist_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      sums[wr_bin]       <= wr_sum;
      hist[hist_wr_addr] <= wr_mag;
    end
  end

endmodule

`default_nettype wire

### rtl/sfma_div.sv
// Iterative restoring divider: running sum over a small frame count.
// Depends on sfma_pkg; resolves DIV_STEPS quotient bits per cycle.
`default_nettype none

module sfma_div
  import sfma_pkg::*;
#(
  parameter int VW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [VW-1:0]     divisor,
  output logic                   done,
  output logic      [SUM_W-1:0]  quotient
);

  localparam int ITER = SUM_W / DIV_STEPS;
  localparam int CW   = $clog2(ITER + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [VW-1:0]    dvs;
  logic [VW:0]      rem;
  logic [SUM_W-1:0] quo;
  logic [VW:0]      rem_next;
  logic [SUM_W-1:0] quo_next;

  // Dividend bits leave at the top of quo while quotient bits enter below.
  always_comb begin
    logic [VW:0]      r;
    logic [SUM_W-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[VW-1:0], q[SUM_W-1]};
      q = {q[SUM_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(ITER);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire
